/* hdl/emt_pkg.sv */
// extent map translator package: field widths, stream packing, codes and shared types
// used by emt_lookup and extent_map_translator; no dependencies
`default_nettype none

package emt_pkg;

  // block geometry
  localparam int BLK_SHIFT   = 12;
  localparam int BLOCK_BYTES = 1 << BLK_SHIFT;

  // field widths
  localparam int TYPE_W   = 2;
  localparam int OFF_W    = 40;
  localparam int LEN_W    = 18;
  localparam int LBLK_W   = 28;
  localparam int PBLK_W   = 32;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 44;
  localparam int SEG_W    = 13;
  localparam int POS_W    = OFF_W + 1;
  localparam int BNUM_W   = POS_W - BLK_SHIFT;

  // longest request, in bytes
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(63 * BLOCK_BYTES);

  // input tdata layout
  localparam int S_OFF_LSB   = 0;
  localparam int S_LEN_LSB   = S_OFF_LSB + OFF_W;
  localparam int S_LSTRT_LSB = S_LEN_LSB + LEN_W;
  localparam int S_PSTRT_LSB = S_LSTRT_LSB + LBLK_W;
  localparam int S_CNT_LSB   = S_PSTRT_LSB + PBLK_W;
  localparam int S_USED_W    = S_CNT_LSB + LBLK_W;
  localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;
  localparam int S_TUSER_W   = TYPE_W;

  // output tdata / tuser layout
  localparam int M_USED_W  = ADDR_W + SEG_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int M_TUSER_W = STATUS_W + 1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_IGNORE = 2'd3
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EOF      = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_ZERO_LEN = 3'd4
  } status_e;

  typedef struct packed {
    logic [LBLK_W-1:0] count;
    logic [PBLK_W-1:0] phys;
    logic [LBLK_W-1:0] start;
  } extent_t;

  typedef struct packed {
    logic              start;
    logic [BNUM_W-1:0] lblock;
  } lookup_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [PBLK_W-1:0] pblock;
  } lookup_rsp_t;

  typedef enum logic [1:0] {
    LK_IDLE = 2'd0,
    LK_SCAN = 2'd1,
    LK_MAP  = 2'd2
  } lk_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE      = 3'd0,
    SQ_DECODE    = 3'd1,
    SQ_CHK_LOOK  = 3'd2,
    SQ_CHK_WAIT  = 3'd3,
    SQ_SEG_LOOK  = 3'd4,
    SQ_SEG_WAIT  = 3'd5,
    SQ_SEG_OUT   = 3'd6,
    SQ_STATUS    = 3'd7
  } sq_state_e;

endpackage : emt_pkg

`default_nettype wire

/* hdl/emt_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module emt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : emt_ram

`default_nettype wire

/* hdl/emt_lookup.sv */
// extent lookup unit: scans the extent table one entry per cycle for the first
// extent covering a logical block and returns its physical block; uses emt_pkg
`default_nettype none

module emt_lookup #(
  parameter int MAX_EXTENTS = 16,
  parameter int CW          = $clog2(MAX_EXTENTS + 1),
  parameter int AW          = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire emt_pkg::lookup_req_t req_i,
  input  wire logic [CW-1:0]        used_i,
  output logic      [AW-1:0]        raddr_o,
  input  wire emt_pkg::extent_t     rdata_i,
  output emt_pkg::lookup_rsp_t      rsp_o
);

  import emt_pkg::*;

  lk_state_e           state_q, state_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                done_q, done_d;
  logic                hit_q, hit_d;
  logic [BNUM_W-1:0]   lblock_q, lblock_d;
  logic [PBLK_W-1:0]   phys_q, phys_d;
  logic [LBLK_W-1:0]   diff_q, diff_d;
  logic [PBLK_W-1:0]   pblock_q, pblock_d;
  logic [BNUM_W-1:0]   ext_end;
  logic                hit_now;

  assign raddr_o = idx_q[AW-1:0];
  assign ext_end = {1'b0, rdata_i.start} + {1'b0, rdata_i.count};
  // rdata belongs to the entry read in the previous cycle
  assign hit_now = rd_vld_q && (lblock_q >= {1'b0, rdata_i.start}) && (lblock_q < ext_end);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    done_d   = 1'b0;
    hit_d    = hit_q;
    lblock_d = lblock_q;
    phys_d   = phys_q;
    diff_d   = diff_q;
    pblock_d = pblock_q;
    unique case (state_q)
      LK_IDLE: begin
        if (req_i.start) begin
          lblock_d = req_i.lblock;
          idx_d    = '0;
          state_d  = LK_SCAN;
        end
      end
      LK_SCAN: begin
        priority if (hit_now) begin
          phys_d  = rdata_i.phys;
          diff_d  = LBLK_W'(lblock_q - {1'b0, rdata_i.start});
          state_d = LK_MAP;
        end else if (idx_q >= used_i) begin
          hit_d   = 1'b0;
          done_d  = 1'b1;
          state_d = LK_IDLE;
        end else begin
          idx_d    = idx_q + CW'(1);
          rd_vld_d = 1'b1;
        end
      end
      LK_MAP: begin
        pblock_d = phys_q + {{(PBLK_W - LBLK_W){1'b0}}, diff_q};
        hit_d    = 1'b1;
        done_d   = 1'b1;
        state_d  = LK_IDLE;
      end
      default: begin
        state_d = LK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LK_IDLE;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    lblock_q <= lblock_d;
    phys_q   <= phys_d;
    diff_q   <= diff_d;
    pblock_q <= pblock_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.hit    = hit_q;
  assign rsp_o.pblock = pblock_q;

endmodule : emt_lookup

`default_nettype wire

/* hdl/extent_map_translator.sv */
// extent map translator top level: request sequencer, extent table ram, output register
// uses emt_pkg, emt_ram, emt_lookup
//
//  channel  | dir | tdata                                        | tuser               | tlast
//  s_axis   | in  | offset, length, log start, phys start, count | req_type            | -
//  m_axis   | out | disk_address, segment_length                 | status, is_hole     | last_seg
//
// an add or status-only request runs decode and status, then waits for the output handshake
// each segment waits on a lookup that scans the table up to the matching extent, or over
// all used extents on a hole; a write first checks every block the same way
// the lookup unit scans the extent ram one entry per cycle, one lookup at a time
// s_axis_tready_o is high only while idle; a stalled result holds the sequencer
// reset empties the table and zeroes the file size; table contents need no clearing
`default_nettype none

module extent_map_translator #(
  parameter int MAX_EXTENTS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // byte_offset, byte_length, extent_logical_start, extent_physical_start,
  // extent_block_count, zero fill
  input  wire logic [emt_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // req_type
  input  wire logic [emt_pkg::S_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // disk_address, segment_length, zero fill
  output logic      [emt_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // status, is_hole
  output logic      [emt_pkg::M_TUSER_W-1:0]     m_axis_tuser_o,
  // last_seg
  output logic                                   m_axis_tlast_o
);

  import emt_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  sq_state_e          state_q, state_d;
  req_type_e          type_q, type_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [POS_W-1:0]   end_q, end_d;
  extent_t            ext_q, ext_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BNUM_W-1:0]  blk_q, blk_d;
  logic [BNUM_W-1:0]  last_blk_q, last_blk_d;
  logic [CW-1:0]      used_q, used_d;
  logic [POS_W-1:0]   fsize_q, fsize_d;
  status_e            status_q, status_d;
  logic               hit_q, hit_d;
  logic [PBLK_W-1:0]  pb_q, pb_d;

  logic               m_valid_q, m_valid_d;
  status_e            m_status_q, m_status_d;
  logic [ADDR_W-1:0]  m_addr_q, m_addr_d;
  logic [SEG_W-1:0]   m_len_q, m_len_d;
  logic               m_hole_q, m_hole_d;
  logic               m_last_q, m_last_d;

  logic               in_xfer;
  logic               out_free;
  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   in_len_cap;
  logic [OFF_W-1:0]   in_off;
  logic [BLK_SHIFT-1:0] inb;
  logic [SEG_W-1:0]   room;
  logic [SEG_W-1:0]   chunk;
  logic               seg_last;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [$bits(extent_t)-1:0] ram_rdata;
  lookup_req_t        lk_req;
  lookup_rsp_t        lk_rsp;

  assign s_axis_tready_o = (state_q == SQ_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign in_off     = s_axis_tdata_i[S_OFF_LSB +: OFF_W];
  assign in_len     = s_axis_tdata_i[S_LEN_LSB +: LEN_W];
  assign in_len_cap = (in_len > LEN_CAP) ? LEN_CAP : in_len;

  // segment runs to the block boundary or the end of the request
  assign inb      = pos_q[BLK_SHIFT-1:0];
  assign room     = SEG_W'(BLOCK_BYTES) - {1'b0, inb};
  assign chunk    = ({{(LEN_W - SEG_W){1'b0}}, room} > len_q) ? len_q[SEG_W-1:0] : room;
  assign seg_last = (len_q == {{(LEN_W - SEG_W){1'b0}}, chunk});

  emt_ram #(
    .WIDTH ($bits(extent_t)),
    .DEPTH (MAX_EXTENTS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (used_q[AW-1:0]),
    .wdata_i (ext_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  emt_lookup #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .CW          (CW),
    .AW          (AW)
  ) u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lk_req),
    .used_i  (used_q),
    .raddr_o (ram_raddr),
    .rdata_i (extent_t'(ram_rdata)),
    .rsp_o   (lk_rsp)
  );

  always_comb begin
    state_d    = state_q;
    type_d     = type_q;
    off_d      = off_q;
    len_d      = len_q;
    end_d      = end_q;
    ext_d      = ext_q;
    pos_d      = pos_q;
    blk_d      = blk_q;
    last_blk_d = last_blk_q;
    used_d     = used_q;
    fsize_d    = fsize_q;
    status_d   = status_q;
    hit_d      = hit_q;
    pb_d       = pb_q;
    ram_we     = 1'b0;
    lk_req.start  = 1'b0;
    lk_req.lblock = blk_q;

    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_status_d = m_status_q;
    m_addr_d   = m_addr_q;
    m_len_d    = m_len_q;
    m_hole_d   = m_hole_q;
    m_last_d   = m_last_q;

    unique case (state_q)
      SQ_IDLE: begin
        if (in_xfer) begin
          type_d      = req_type_e'(s_axis_tuser_i);
          off_d       = in_off;
          len_d       = in_len_cap;
          end_d       = {1'b0, in_off} + {{(POS_W - LEN_W){1'b0}}, in_len_cap};
          ext_d.start = s_axis_tdata_i[S_LSTRT_LSB +: LBLK_W];
          ext_d.phys  = s_axis_tdata_i[S_PSTRT_LSB +: PBLK_W];
          ext_d.count = s_axis_tdata_i[S_CNT_LSB +: LBLK_W];
          state_d     = SQ_DECODE;
        end
      end
      SQ_DECODE: begin
        unique case (type_q)
          REQ_ADD: begin
            if (used_q >= CW'(MAX_EXTENTS)) begin
              status_d = ST_FULL;
            end else begin
              ram_we   = 1'b1;
              used_d   = used_q + CW'(1);
              status_d = ST_OK;
            end
            state_d = SQ_STATUS;
          end
          REQ_IGNORE: begin
            state_d = SQ_IDLE;
          end
          REQ_READ, REQ_WRITE: begin
            priority if (len_q == '0) begin
              status_d = ST_ZERO_LEN;
              state_d  = SQ_STATUS;
            end else if (type_q == REQ_READ) begin
              if ({1'b0, off_q} >= fsize_q) begin
                status_d = ST_EOF;
                state_d  = SQ_STATUS;
              end else begin
                // clip the read at the end of the file
                if (end_q > fsize_q) begin
                  len_d = LEN_W'(fsize_q - {1'b0, off_q});
                end
                pos_d   = {1'b0, off_q};
                state_d = SQ_SEG_LOOK;
              end
            end else begin
              pos_d      = {1'b0, off_q};
              blk_d      = {1'b0, off_q[OFF_W-1:BLK_SHIFT]};
              last_blk_d = BNUM_W'((end_q - POS_W'(1)) >> BLK_SHIFT);
              state_d    = SQ_CHK_LOOK;
            end
          end
          default: begin
            state_d = SQ_IDLE;
          end
        endcase
      end
      SQ_CHK_LOOK: begin
        lk_req.start  = 1'b1;
        lk_req.lblock = blk_q;
        state_d       = SQ_CHK_WAIT;
      end
      SQ_CHK_WAIT: begin
        if (lk_rsp.done) begin
          priority if (!lk_rsp.hit) begin
            status_d = ST_UNMAPPED;
            state_d  = SQ_STATUS;
          end else if (blk_q == last_blk_q) begin
            // every block mapped: the write goes ahead and may grow the file
            if (end_q > fsize_q) begin
              fsize_d = end_q;
            end
            state_d = SQ_SEG_LOOK;
          end else begin
            blk_d   = blk_q + BNUM_W'(1);
            state_d = SQ_CHK_LOOK;
          end
        end
      end
      SQ_SEG_LOOK: begin
        lk_req.start  = 1'b1;
        lk_req.lblock = pos_q[POS_W-1:BLK_SHIFT];
        state_d       = SQ_SEG_WAIT;
      end
      SQ_SEG_WAIT: begin
        if (lk_rsp.done) begin
          hit_d   = lk_rsp.hit;
          pb_d    = lk_rsp.pblock;
          state_d = SQ_SEG_OUT;
        end
      end
      SQ_SEG_OUT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_OK;
          m_addr_d   = hit_q ? {pb_q, inb} : '0;
          m_len_d    = chunk;
          m_hole_d   = !hit_q;
          m_last_d   = seg_last;
          pos_d      = pos_q + {{(POS_W - SEG_W){1'b0}}, chunk};
          len_d      = len_q - {{(LEN_W - SEG_W){1'b0}}, chunk};
          state_d    = seg_last ? SQ_IDLE : SQ_SEG_LOOK;
        end
      end
      SQ_STATUS: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_addr_d   = '0;
          m_len_d    = '0;
          m_hole_d   = 1'b0;
          m_last_d   = 1'b1;
          state_d    = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SQ_IDLE;
      used_q    <= '0;
      fsize_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      fsize_q   <= fsize_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    off_q      <= off_d;
    len_q      <= len_d;
    end_q      <= end_d;
    ext_q      <= ext_d;
    pos_q      <= pos_d;
    blk_q      <= blk_d;
    last_blk_q <= last_blk_d;
    status_q   <= status_d;
    hit_q      <= hit_d;
    pb_q       <= pb_d;
    m_status_q <= m_status_d;
    m_addr_q   <= m_addr_d;
    m_len_q    <= m_len_d;
    m_hole_q   <= m_hole_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - M_USED_W){1'b0}}, m_len_q, m_addr_q};
  assign m_axis_tuser_o  = {m_hole_q, m_status_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule : extent_map_translator

`default_nettype wire

/* bench/extent_map_translator_tb.sv */
// self-checking bench for extent_map_translator: directed and random add, read and write
// requests, results predicted in a scoreboard class; depends on emt_pkg and the rtl only
`default_nettype none

module extent_map_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emt_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int SEG_CAP_BYTES  = 63 * BLOCK_BYTES;
  localparam int MAX_SEGS       = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 300;

  typedef struct {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [SEG_W-1:0]  seg_len;
    logic              hole;
    logic              last;
  } seg_result_t;

  class translation_scoreboard;
    logic [LBLK_W-1:0] ext_lstart[TABLE_DEPTH];
    logic [PBLK_W-1:0] ext_pstart[TABLE_DEPTH];
    logic [LBLK_W-1:0] ext_count[TABLE_DEPTH];
    int unsigned       used;
    logic [POS_W-1:0]  file_size;
    seg_result_t       pending_segments[$];
    int                errors;

    function new();
      used      = 0;
      file_size = '0;
      errors    = 0;
    endfunction

    function bit lookup_block(longint unsigned lblk, output longint unsigned pblk);
      longint unsigned base;
      pblk = 0;
      for (int i = 0; i < used; i++) begin
        base = ext_lstart[i];
        if (lblk >= base && lblk < base + ext_count[i]) begin
          pblk = ext_pstart[i] + (lblk - base);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void want_status(status_e st);
      seg_result_t r;
      r.status  = st;
      r.addr    = '0;
      r.seg_len = '0;
      r.hole    = 1'b0;
      r.last    = 1'b1;
      pending_segments.push_back(r);
    endfunction

    // cut [pos, pos+span) at block boundaries
    function void split_range(longint unsigned pos, longint unsigned span);
      seg_result_t     r;
      longint unsigned lblk;
      longint unsigned inb;
      longint unsigned chunk;
      longint unsigned pblk;
      int              n;
      n = 0;
      while (span > 0 && n < MAX_SEGS) begin
        lblk  = pos / BLOCK_BYTES;
        inb   = pos % BLOCK_BYTES;
        chunk = BLOCK_BYTES - inb;
        if (chunk > span) chunk = span;
        span -= chunk;
        r.status  = ST_OK;
        r.seg_len = SEG_W'(chunk);
        r.last    = (span == 0);
        if (lookup_block(lblk, pblk)) begin
          r.addr = ADDR_W'(pblk * BLOCK_BYTES + inb);
          r.hole = 1'b0;
        end else begin
          r.addr = '0;
          r.hole = 1'b1;
        end
        pending_segments.push_back(r);
        pos += chunk;
        n++;
      end
    endfunction

    function void note_request(req_type_e kind, logic [OFF_W-1:0] off,
                               logic [LEN_W-1:0] len, logic [LBLK_W-1:0] lstart,
                               logic [PBLK_W-1:0] pstart, logic [LBLK_W-1:0] count);
      longint unsigned span;
      longint unsigned pos;
      longint unsigned blk;
      longint unsigned last_blk;
      longint unsigned pblk;
      span = len;
      pos  = off;
      case (kind)
        REQ_ADD: begin
          if (used >= TABLE_DEPTH) begin
            want_status(ST_FULL);
          end else begin
            ext_lstart[used] = lstart;
            ext_pstart[used] = pstart;
            ext_count[used]  = count;
            used++;
            want_status(ST_OK);
          end
        end
        REQ_READ, REQ_WRITE: begin
          if (span == 0) begin
            want_status(ST_ZERO_LEN);
            return;
          end
          if (span > SEG_CAP_BYTES) span = SEG_CAP_BYTES;
          if (kind == REQ_READ) begin
            if (pos >= file_size) begin
              want_status(ST_EOF);
              return;
            end
            if (pos + span > file_size) span = file_size - pos;
          end else begin
            // every touched block must be mapped before anything goes out
            last_blk = (pos + span - 1) / BLOCK_BYTES;
            for (blk = pos / BLOCK_BYTES; blk <= last_blk; blk++) begin
              if (!lookup_block(blk, pblk)) begin
                want_status(ST_UNMAPPED);
                return;
              end
            end
            if (pos + span > file_size) file_size = POS_W'(pos + span);
          end
          split_range(pos, span);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user,
                               logic last);
      seg_result_t want;
      if (pending_segments.size() == 0) begin
        errors++;
        $display("%0t: transfer with nothing expected, expected none actual status %0h",
                 $time, user[STATUS_W-1:0]);
        return;
      end
      want = pending_segments.pop_front();
      compare_field("status", want.status, user[STATUS_W-1:0]);
      compare_field("disk_address", want.addr, data[ADDR_W-1:0]);
      compare_field("segment_length", want.seg_len, data[ADDR_W +: SEG_W]);
      compare_field("is_hole", want.hole, user[STATUS_W]);
      compare_field("last_seg", want.last, last);
    endfunction

    function int pending();
      return pending_segments.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [M_TUSER_W-1:0] m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  translation_scoreboard book = new();
  bit                    steady_run = 1'b0;
  int                    quiet_cycles = 0;

  extent_map_translator #(.MAX_EXTENTS(TABLE_DEPTH)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stalls at random outside the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready_i <= steady_run || ($urandom_range(99) >= 37);
  end

  // sample mid-cycle so nothing depends on event order at the edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      book.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge, returns at the edge where the request transfer took place
  task automatic send_request(req_type_e kind, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                              logic [LBLK_W-1:0] lstart, logic [PBLK_W-1:0] pstart,
                              logic [LBLK_W-1:0] count);
    if (!steady_run) begin
      while ($urandom_range(99) < 37) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_TDATA_W'({count, pstart, lstart, len, off});
    s_axis_tuser_i  <= kind;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    book.note_request(kind, off, len, lstart, pstart, count);
    @(posedge clk_i);
  endtask

  task automatic send_add(logic [LBLK_W-1:0] lstart, logic [PBLK_W-1:0] pstart,
                          logic [LBLK_W-1:0] count);
    send_request(REQ_ADD, OFF_W'({$urandom, $urandom}), LEN_W'($urandom), lstart, pstart,
                 count);
  endtask

  task automatic send_access(req_type_e kind, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
    send_request(kind, off, len, LBLK_W'($urandom), $urandom, LBLK_W'($urandom));
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return LEN_W'($urandom_range(1, 8192));
    if (roll < 90) return LEN_W'($urandom_range(1, 40000));
    return LEN_W'($urandom_range(40000, (1 << LEN_W) - 1));
  endfunction

  initial begin
    int              roll;
    int              k;
    int              candidates[$];
    longint unsigned blk;
    longint unsigned off;
    longint unsigned room;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table and empty file
    send_access(REQ_READ, 40'd0, 18'd5);
    send_access(REQ_WRITE, 40'd0, 18'd0);
    send_access(REQ_READ, 40'd123, 18'd0);
    send_access(REQ_IGNORE, 40'd77, 18'd500);
    send_access(REQ_WRITE, 40'd0, 18'd100);
    // second extent overlaps the first and its disk address wraps
    send_add(28'd0, 32'h0000_1000, 28'd8);
    send_add(28'd4, 32'hFFFF_FFFE, 28'd8);
    send_add(28'd20, 32'h0001_2345, 28'd0);
    send_add(28'h800_0000, 32'h00AB_CDEF, 28'hFFF_FFFF);
    send_access(REQ_WRITE, 40'd100, LEN_W'(11 * BLOCK_BYTES));
    send_access(REQ_WRITE, OFF_W'(20 * BLOCK_BYTES), 18'd10);
    send_access(REQ_WRITE, OFF_W'(11 * BLOCK_BYTES + 5), 18'd8000);
    send_access(REQ_READ, 40'd45156, 18'd1);
    send_access(REQ_READ, 40'd45000, 18'd1000);
    send_access(REQ_READ, 40'd0, LEN_W'(SEG_CAP_BYTES));
    send_add(28'd30, 32'h0000_0200, 28'd100);
    send_access(REQ_WRITE, OFF_W'(30 * BLOCK_BYTES), LEN_W'(40 * BLOCK_BYTES));
    // longest read, holes in the middle
    send_access(REQ_READ, 40'd1, '1);
    send_access(REQ_WRITE, OFF_W'(129 * BLOCK_BYTES + 4000), 18'd200);
    send_access(REQ_WRITE, 40'd2, '1);
    send_access(REQ_WRITE, OFF_W'(30 * BLOCK_BYTES + 7), '1);
    send_access(REQ_READ, OFF_W'(8 * BLOCK_BYTES - 3), 18'd10);

    for (int i = 0; i < 255; i++) begin
      steady_run = (i >= 90 && i < 150);
      roll = $urandom_range(99);
      if (roll < 25 && book.used < TABLE_DEPTH) begin
        send_add(LBLK_W'($urandom_range(0, 200)), $urandom, LBLK_W'($urandom_range(0, 12)));
      end else if (roll < 30) begin
        send_add(LBLK_W'($urandom), $urandom, LBLK_W'($urandom));
      end else if (roll < 33) begin
        send_access(REQ_IGNORE, OFF_W'({$urandom, $urandom}), pick_length());
      end else if (roll < 36) begin
        send_access(roll[0] ? REQ_READ : REQ_WRITE, OFF_W'({$urandom, $urandom}), '0);
      end else if (roll < 66) begin
        // mostly writes that land inside one low extent
        candidates.delete();
        for (k = 0; k < book.used; k++) begin
          if (book.ext_count[k] != 0 && book.ext_lstart[k] + book.ext_count[k] <= 4096)
            candidates.push_back(k);
        end
        if (candidates.size() != 0 && $urandom_range(99) < 70) begin
          k    = candidates[$urandom_range(0, candidates.size() - 1)];
          blk  = book.ext_lstart[k] + $urandom_range(0, book.ext_count[k] - 1);
          off  = blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
          room = (book.ext_lstart[k] + book.ext_count[k]) * BLOCK_BYTES - off;
          send_access(REQ_WRITE, OFF_W'(off),
                      LEN_W'($urandom_range(1, room < 12288 ? room : 12288)));
        end else begin
          send_access(REQ_WRITE, OFF_W'($urandom_range(0, 230 * BLOCK_BYTES)), pick_length());
        end
      end else begin
        if ($urandom_range(99) < 10)
          off = OFF_W'({$urandom, $urandom});
        else
          off = $urandom_range(0, 32'(book.file_size) + 8192);
        send_access(REQ_READ, OFF_W'(off), pick_length());
      end
    end
    steady_run = 1'b0;

    // top of the offset range, file size reaching its widest value
    send_access(REQ_WRITE, 40'hFF_FFFF_D011, 18'd9000);
    send_access(REQ_READ, 40'hFF_FFFF_CFAD, '1);
    send_access(REQ_WRITE, 40'hFF_FFFF_FFFF, 18'd1);
    send_access(REQ_READ, 40'hFF_FFFF_FFFF, 18'd5);
    send_access(REQ_READ, 40'h7F_FFFF_FFFB, 18'd20);
    send_add('1, '1, '1);
    s_axis_tvalid_i <= 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/emt_pkg.sv
hdl/emt_ram.sv
hdl/emt_lookup.sv
hdl/extent_map_translator.sv
bench/extent_map_translator_tb.sv
